### hw/rtl/slist_pkg.sv
// Package for the sorted list block: opcodes, status codes and the control
// bundle that the top level broadcasts to every storage cell.
// No dependencies.
package slist_pkg;

    localparam int DATA_W   = 32;
    localparam int POS_W    = 7;
    localparam int LENGTH_W = 8;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_READ   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    // Broadcast to all cells. The compare flags are taken on capture; the
    // entry moves on insert_en or delete_en.
    typedef struct packed {
        logic                     capture;
        logic                     insert_en;
        logic                     delete_en;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

### hw/rtl/slist_cell.sv
// One storage cell of the sorted list: holds one entry, compares it with the
// broadcast value and shifts toward or from its neighbors.
// Depends on slist_pkg.
module slist_cell
(
    input  logic                                clk,
    input  slist_pkg::cell_ctrl_t               ctrl,
    input  logic                                used,
    input  logic                                hit,
    input  logic                                left_open,
    input  logic                                left_ge,
    input  logic signed [slist_pkg::DATA_W-1:0] left_entry,
    input  logic signed [slist_pkg::DATA_W-1:0] right_entry,
    output logic signed [slist_pkg::DATA_W-1:0] entry,
    output logic                                open_flag,
    output logic                                ge_flag,
    output logic                                found,
    output logic        [slist_pkg::DATA_W-1:0] rd_data
);

    logic signed [slist_pkg::DATA_W-1:0] entry_reg;
    logic signed [slist_pkg::DATA_W-1:0] entry_next;
    logic                                used_reg;
    logic                                gt_reg;
    logic                                ge_reg;
    logic                                eq_reg;
    logic                                hit_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            used_reg <= used;
            gt_reg   <= used && (entry_reg > ctrl.value);
            ge_reg   <= used && (entry_reg >= ctrl.value);
            eq_reg   <= used && (entry_reg == ctrl.value);
            hit_reg  <= hit;
        end
    end

    // A cell is open when it sits at or past the insertion slot. The slot
    // itself is the first open cell; every open cell after it takes its
    // left neighbor's entry.
    assign open_flag = !used_reg || gt_reg;
    assign ge_flag   = ge_reg;
    // The list is sorted, so the first equal entry is the first one not
    // below the value.
    assign found     = eq_reg && !left_ge;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert_en)
        begin
            if (left_open)
            begin
                entry_next = left_entry;
            end
            else if (open_flag)
            begin
                entry_next = ctrl.value;
            end
        end
        else if (ctrl.delete_en && ge_reg)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry   = entry_reg;
    assign rd_data = (hit_reg && used_reg) ? entry_reg : '0;

endmodule

### hw/rtl/sorted_list_insert_delete.sv
// Top level of the sorted list: request and result handshakes, the entry
// count, and a row of slist_cell instances that hold the entries in order.
// Depends on slist_pkg and slist_cell.
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_ready   opcode, value, position
//  out      output     out_valid / out_ready status, read_value, length,
//                                            empty_flag, full_flag
//
// On acceptance every cell compares its entry with the value; in the apply
// state the cells shift and the result is registered. A new request is
// taken in the cycle after that, even while the previous result still
// waits. The apply cycle stalls only while an older result is held by
// out_ready. Reset empties the list; entries need no clear.
module sorted_list_insert_delete
#(
    parameter int CAPACITY = 128
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          opcode,
    input  logic signed [slist_pkg::DATA_W-1:0] value,
    input  logic [slist_pkg::POS_W-1:0]         position,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic signed [slist_pkg::DATA_W-1:0] read_value,
    output logic [slist_pkg::LENGTH_W-1:0]      length,
    output logic                                empty_flag,
    output logic                                full_flag
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CW > slist_pkg::POS_W) ? CW : slist_pkg::POS_W;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_APPLY = 2'b10
    } state_t;

    state_t                              state_reg;
    state_t                              state_next;
    logic [CW-1:0]                       count_reg;
    logic [CW-1:0]                       count_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    slist_pkg::opcode_t                  op_reg;
    logic signed [slist_pkg::DATA_W-1:0] value_reg;
    logic                                range_ok_reg;

    logic                                accept;
    logic                                apply_fire;
    logic                                list_full;
    logic                                any_found;
    logic [slist_pkg::DATA_W-1:0]        rd_any;
    slist_pkg::status_t                  status_next;
    logic [slist_pkg::DATA_W-1:0]        read_value_next;
    slist_pkg::cell_ctrl_t               ctrl;

    logic        [CAPACITY-1:0]          used_vec;
    logic        [CAPACITY-1:0]          hit_vec;
    logic        [CAPACITY-1:0]          open_vec;
    logic        [CAPACITY-1:0]          ge_vec;
    logic        [CAPACITY-1:0]          found_vec;
    logic signed [slist_pkg::DATA_W-1:0] entry_arr [CAPACITY];
    logic        [slist_pkg::DATA_W-1:0] rd_arr    [CAPACITY];

    logic [1:0]                          status_reg;
    logic [slist_pkg::DATA_W-1:0]        read_value_reg;
    logic [slist_pkg::LENGTH_W-1:0]      length_reg;
    logic                                empty_reg;
    logic                                full_reg;

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign apply_fire = (state_reg == S_APPLY) && (!out_valid_reg || out_ready);
    assign list_full  = (count_reg == CW'(CAPACITY));

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            used_vec[i] = (CW'(i) < count_reg);
            hit_vec[i]  = (IW'(i) == IW'(position));
        end
    end

    assign ctrl.capture   = accept;
    assign ctrl.insert_en = apply_fire && (op_reg == slist_pkg::OP_INSERT) && !list_full;
    assign ctrl.delete_en = apply_fire && (op_reg == slist_pkg::OP_DELETE) && any_found;
    assign ctrl.value     = accept ? value : value_reg;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic                                l_open;
            logic                                l_ge;
            logic signed [slist_pkg::DATA_W-1:0] l_entry;
            logic signed [slist_pkg::DATA_W-1:0] r_entry;

            if (g == 0)
            begin : g_first
                assign l_open  = 1'b0;
                assign l_ge    = 1'b0;
                assign l_entry = '0;
            end
            else
            begin : g_inner
                assign l_open  = open_vec[g-1];
                assign l_ge    = ge_vec[g-1];
                assign l_entry = entry_arr[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign r_entry = '0;
            end
            else
            begin : g_body
                assign r_entry = entry_arr[g+1];
            end

            slist_cell u_cell
            (
                .clk         (clk),
                .ctrl        (ctrl),
                .used        (used_vec[g]),
                .hit         (hit_vec[g]),
                .left_open   (l_open),
                .left_ge     (l_ge),
                .left_entry  (l_entry),
                .right_entry (r_entry),
                .entry       (entry_arr[g]),
                .open_flag   (open_vec[g]),
                .ge_flag     (ge_vec[g]),
                .found       (found_vec[g]),
                .rd_data     (rd_arr[g])
            );
        end
    endgenerate

    assign any_found = |found_vec;

    // At most one cell drives a nonzero read word, so an OR tree acts as the mux.
    always_comb
    begin
        rd_any = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_any = rd_any | rd_arr[i];
        end
    end

    always_comb
    begin
        count_next      = count_reg;
        status_next     = slist_pkg::ST_OK;
        read_value_next = '0;
        case (op_reg)
            slist_pkg::OP_INSERT:
            begin
                if (list_full)
                begin
                    status_next = slist_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            slist_pkg::OP_DELETE:
            begin
                if (any_found)
                begin
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    status_next = slist_pkg::ST_NOT_FOUND;
                end
            end
            slist_pkg::OP_CLEAR:
            begin
                count_next = '0;
            end
            slist_pkg::OP_READ:
            begin
                if (range_ok_reg)
                begin
                    read_value_next = rd_any;
                end
                else
                begin
                    status_next = slist_pkg::ST_RANGE;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (apply_fire)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (apply_fire)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= slist_pkg::opcode_t'(opcode);
            value_reg    <= value;
            range_ok_reg <= (IW'(position) < IW'(count_reg));
        end
        if (apply_fire)
        begin
            status_reg     <= status_next;
            read_value_reg <= read_value_next;
            length_reg     <= slist_pkg::LENGTH_W'(count_next);
            empty_reg      <= (count_next == '0);
            full_reg       <= (count_next == CW'(CAPACITY));
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign read_value = read_value_reg;
    assign length     = length_reg;
    assign empty_flag = empty_reg;
    assign full_flag  = full_reg;

`ifndef SYNTHESIS
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(empty_flag && full_flag))
        else $error("empty and full reported together");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == slist_pkg::ST_FULL) |-> full_flag)
        else $error("refused insert while list not full");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != slist_pkg::ST_OK) |-> (read_value == '0))
        else $error("read value nonzero on a failed request");

    a_accept_apply: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> (state_reg == S_APPLY))
        else $error("accepted request did not enter apply cycle");
`endif

endmodule

### dv/tb_top.sv
// Testbench for the sorted list block: drives insert, delete, clear and read
// requests, predicts every result from its own copy of the list and checks it.
// Depends on slist_pkg and sorted_list_insert_delete.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY    = 128;
    localparam int DATA_W      = slist_pkg::DATA_W;
    localparam int POS_W       = slist_pkg::POS_W;
    localparam int LENGTH_W    = slist_pkg::LENGTH_W;
    localparam int IDLE_PCT    = 19;
    localparam int REPORT_MAX  = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 20;

    typedef struct {
        slist_pkg::status_t       status;
        logic signed [DATA_W-1:0] read_value;
        logic [LENGTH_W-1:0]      length;
        logic                     empty_flag;
        logic                     full_flag;
    } list_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [1:0]               opcode;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
    logic                     out_valid;
    logic                     out_ready;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] read_value;
    logic [LENGTH_W-1:0]      length;
    logic                     empty_flag;
    logic                     full_flag;

    list_result_t             pending_results[$];
    logic signed [DATA_W-1:0] shadow_list[CAPACITY];
    int                       shadow_count;
    int                       mismatches;
    int                       cycle_count;
    bit                       steady;

    sorted_list_insert_delete #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .value      (value),
        .position   (position),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .read_value (read_value),
        .length     (length),
        .empty_flag (empty_flag),
        .full_flag  (full_flag)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Applies one request to the local copy of the list and returns its result.
    function automatic list_result_t apply_request(slist_pkg::opcode_t op,
                                                   logic signed [DATA_W-1:0] v,
                                                   logic [POS_W-1:0] pos);
        list_result_t r;
        int           slot;
        r.status     = slist_pkg::ST_OK;
        r.read_value = '0;
        case (op)
            slist_pkg::OP_INSERT:
            begin
                if (shadow_count >= CAPACITY)
                    r.status = slist_pkg::ST_FULL;
                else
                begin
                    // Equal values stay ahead of the new one.
                    slot = 0;
                    while (slot < shadow_count && shadow_list[slot] <= v)
                        slot++;
                    for (int i = shadow_count; i > slot; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[slot] = v;
                    shadow_count++;
                end
            end
            slist_pkg::OP_DELETE:
            begin
                slot = 0;
                while (slot < shadow_count && shadow_list[slot] != v)
                    slot++;
                if (slot >= shadow_count)
                    r.status = slist_pkg::ST_NOT_FOUND;
                else
                begin
                    for (int i = slot; i + 1 < shadow_count; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_count--;
                end
            end
            slist_pkg::OP_CLEAR:
                shadow_count = 0;
            default:
            begin
                if (pos < shadow_count)
                    r.read_value = shadow_list[pos];
                else
                    r.status = slist_pkg::ST_RANGE;
            end
        endcase
        r.length     = shadow_count[LENGTH_W-1:0];
        r.empty_flag = (shadow_count == 0);
        r.full_flag  = (shadow_count >= CAPACITY);
        return r;
    endfunction

    // Values already in the list most often, so that deletes find something,
    // then small values that collide often, the extremes and full-range noise.
    function automatic logic signed [DATA_W-1:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 45 && shadow_count > 0)
            return shadow_list[$urandom_range(shadow_count - 1)];
        if (roll < 78)
            return $signed($urandom_range(16)) - 8;
        if (roll < 82)
            return {1'b1, {(DATA_W-1){1'b0}}};
        if (roll < 86)
            return {1'b0, {(DATA_W-1){1'b1}}};
        return $urandom();
    endfunction

    function automatic int pick_position();
        if ($urandom_range(99) < 65)
            return $urandom_range(shadow_count);
        return $urandom_range((1 << POS_W) - 1);
    endfunction

    task automatic send_request(slist_pkg::opcode_t op, logic signed [DATA_W-1:0] v,
                                int pos);
        logic [POS_W-1:0] pos_bits;
        pos_bits = POS_W'(pos);
        @(negedge clk);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        opcode   = op;
        value    = v;
        position = pos_bits;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(apply_request(op, v, pos_bits));
    endtask

    task automatic report_mismatch(string what, list_result_t want);
        mismatches++;
        if (mismatches <= REPORT_MAX)
        begin
            $display("%0t %s: expected status %0d read_value %0d length %0d empty %0b full %0b",
                     $realtime, what, want.status, want.read_value, want.length,
                     want.empty_flag, want.full_flag);
            $display("    got status %0d read_value %0d length %0d empty %0b full %0b",
                     status, read_value, length, empty_flag, full_flag);
        end
    endtask

    task automatic check_result();
        list_result_t want;
        if (pending_results.size() == 0)
        begin
            want = '{slist_pkg::ST_OK, '0, '0, 1'b0, 1'b0};
            report_mismatch("result with no request outstanding", want);
        end
        else
        begin
            want = pending_results.pop_front();
            if (status !== want.status || read_value !== want.read_value ||
                length !== want.length || empty_flag !== want.empty_flag ||
                full_flag !== want.full_flag)
                report_mismatch("result differs", want);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_result();
    end

    task automatic wait_for_drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_directed_edges();
        logic signed [DATA_W-1:0] most_neg;
        logic signed [DATA_W-1:0] most_pos;
        most_neg = {1'b1, {(DATA_W-1){1'b0}}};
        most_pos = {1'b0, {(DATA_W-1){1'b1}}};
        send_request(slist_pkg::OP_READ, 0, 0);
        send_request(slist_pkg::OP_DELETE, 5, 0);
        send_request(slist_pkg::OP_INSERT, 0, 0);
        send_request(slist_pkg::OP_INSERT, most_pos, 0);
        send_request(slist_pkg::OP_INSERT, most_neg, 0);
        send_request(slist_pkg::OP_INSERT, -1, 0);
        send_request(slist_pkg::OP_INSERT, 0, 0);
        send_request(slist_pkg::OP_INSERT, 1, 0);
        for (int p = 0; p < 6; p++)
            send_request(slist_pkg::OP_READ, 0, p);
        send_request(slist_pkg::OP_READ, 0, 6);
        send_request(slist_pkg::OP_READ, -1, (1 << POS_W) - 1);
        send_request(slist_pkg::OP_DELETE, 7, 0);
        send_request(slist_pkg::OP_DELETE, 0, 0);
        send_request(slist_pkg::OP_DELETE, most_neg, 0);
        send_request(slist_pkg::OP_DELETE, most_pos, 0);
        send_request(slist_pkg::OP_READ, 0, 0);
        send_request(slist_pkg::OP_CLEAR, -1, (1 << POS_W) - 1);
        send_request(slist_pkg::OP_READ, 0, 0);
        send_request(slist_pkg::OP_DELETE, -1, 0);
    endtask

    // Fill the list, check that inserts into a full list are refused, then
    // clear it while full.
    task automatic test_fill_and_refuse();
        send_request(slist_pkg::OP_CLEAR, 0, 0);
        while (shadow_count < CAPACITY)
            send_request(slist_pkg::OP_INSERT, pick_value(), pick_position());
        send_request(slist_pkg::OP_INSERT, {1'b1, {(DATA_W-1){1'b0}}}, 0);
        send_request(slist_pkg::OP_INSERT, {1'b0, {(DATA_W-1){1'b1}}}, 0);
        send_request(slist_pkg::OP_READ, 0, CAPACITY - 1);
        send_request(slist_pkg::OP_READ, 0, 0);
        send_request(slist_pkg::OP_DELETE, shadow_list[CAPACITY / 2], 0);
        send_request(slist_pkg::OP_INSERT, 42, 0);
        send_request(slist_pkg::OP_INSERT, 43, 0);
        for (int p = 0; p < CAPACITY; p += 9)
            send_request(slist_pkg::OP_READ, 0, p);
        send_request(slist_pkg::OP_CLEAR, 0, 0);
    endtask

    task automatic test_random_mix(int count);
        int                 insert_pct;
        int unsigned        roll;
        slist_pkg::opcode_t op;
        insert_pct = 50;
        for (int n = 0; n < count; n++)
        begin
            // Pick a new insert share every 150 requests, giving growing and shrinking stretches.
            if (n % 150 == 0)
                insert_pct = $urandom_range(20, 80);
            roll = $urandom_range(99);
            if (roll < 1)
                op = slist_pkg::OP_CLEAR;
            else if (roll < 1 + insert_pct)
                op = slist_pkg::OP_INSERT;
            else if (roll < 1 + insert_pct + (99 - insert_pct) / 2)
                op = slist_pkg::OP_DELETE;
            else
                op = slist_pkg::OP_READ;
            send_request(op, pick_value(), pick_position());
        end
    endtask

    task automatic test_steady_stream();
        steady = 1'b1;
        test_random_mix(250);
        test_fill_and_refuse();
        steady = 1'b0;
    endtask

    task automatic test_pause_until_drained();
        test_random_mix(60);
        wait_for_drain();
        test_random_mix(60);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        opcode       = slist_pkg::OP_INSERT;
        value        = '0;
        position     = '0;
        steady       = 1'b0;
        shadow_count = 0;
        mismatches   = 0;
        cycle_count  = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_edges();
        test_fill_and_refuse();
        test_steady_stream();
        test_pause_until_drained();
        test_random_mix(1050);
        test_fill_and_refuse();

        wait_for_drain();
        repeat (DRAIN_WAIT) @(negedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### sorted_list_insert_delete.f
hw/rtl/slist_pkg.sv
hw/rtl/slist_cell.sv
hw/rtl/sorted_list_insert_delete.sv
dv/tb_top.sv
